// ===== sv/csr_sparse_matvec_macros.svh =====
// Assertion macros for the csm_checker port-level checker of csr_sparse_matvec
`ifndef CSR_SPARSE_MATVEC_MACROS_SVH
`define CSR_SPARSE_MATVEC_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CSM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define CSM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/csm_pkg.sv =====
// Package: constants, types and mode codes of the CSR sparse matrix-vector block
`timescale 1ns / 1ps
package csm_pkg;

    localparam int VECTOR_DEPTH = 1024;
    localparam int VALUE_BITS   = 32;
    localparam int ADDR_BITS    = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
    localparam int PROD_BITS    = 2 * VALUE_BITS;

    localparam int MODE_BITS    = 2;
    localparam int INDEX_BITS   = 10;
    localparam int OPERAND_BITS = 32;
    localparam int CFG_BITS     = 11;
    localparam int SUM_BITS     = 64;
    localparam int ROW_BITS     = 16;

    typedef logic [MODE_BITS-1:0]        t_mode;
    typedef logic [ADDR_BITS-1:0]        t_addr;
    typedef logic signed [VALUE_BITS-1:0] t_value;
    typedef logic signed [SUM_BITS-1:0]  t_sum;
    typedef logic [ROW_BITS-1:0]         t_row;
    typedef logic [CFG_BITS-1:0]         t_cfg;

    localparam t_mode MODE_LOAD    = 2'd0;
    localparam t_mode MODE_NONZERO = 2'd1;
    localparam t_mode MODE_EMPTY   = 2'd2;

    localparam t_cfg COL_COUNT_RESET = 11'd1024;

    localparam t_sum SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam t_sum SUM_MIN = 64'sh8000_0000_0000_0000;

endpackage

// ===== sv/csr_sparse_matvec.sv =====
// Top level: CSR sparse matrix times dense vector, saturating Q32.32 row sums
// A row's closing word passes stage 1 and stage 2 before its result word is registered.
// One word per cycle unless stalled; the store reads or writes at most once a word.
// Stages: store read, multiply, saturating accumulate into the output register.
// Reset: pipeline, accumulator, error flag and row counter clear; column count is 1024.
// The vector store is not cleared by reset; entries are undefined until loaded.
`timescale 1ns / 1ps
module csr_sparse_matvec (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  csm_pkg::t_mode                      i_mode,
    input  logic [csm_pkg::INDEX_BITS-1:0]      i_index,
    input  logic signed [csm_pkg::OPERAND_BITS-1:0] i_operand_value,
    input  logic                                i_row_end,
    input  logic                                i_cfg_wr_en,
    input  logic [csm_pkg::CFG_BITS-1:0]        i_cfg_wr_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [csm_pkg::SUM_BITS-1:0] o_row_sum,
    output logic [csm_pkg::ROW_BITS-1:0]        o_row_number,
    output logic                                o_column_error
);
    import csm_pkg::*;

    logic   advance;
    logic   accept;
    logic   in_range;
    logic   col_ok;
    logic   ram_we;
    logic   ram_re;
    t_addr  ram_addr;
    t_value in_value;
    t_value rd_value;
    logic signed [PROD_BITS-1:0] product;
    logic signed [SUM_BITS:0]    n_sum_wide;
    t_sum   n_sum;
    logic   n_err;

    t_cfg   r_col_count;

    logic   r_s1_valid;
    logic   r_s1_good;
    logic   r_s1_bad;
    logic   r_s1_close;
    t_value r_s1_val;

    logic   r_s2_valid;
    logic   r_s2_bad;
    logic   r_s2_close;
    t_sum   r_s2_prod;

    t_sum   r_acc;
    logic   r_err;
    t_row   r_row;

    logic   r_out_valid;
    t_sum   r_out_sum;
    t_row   r_out_row;
    logic   r_out_err;

    assign advance    = !(r_out_valid && i_out_stall);
    assign accept     = i_in_valid && advance;
    assign o_in_stall = !advance;

    assign in_range = 32'(i_index) < 32'(VECTOR_DEPTH);
    assign col_ok   = in_range && (32'(i_index) < 32'(r_col_count));
    assign ram_addr = ADDR_BITS'(i_index);
    assign in_value = i_operand_value[VALUE_BITS-1:0];
    assign ram_we   = accept && (i_mode == MODE_LOAD) && in_range;
    assign ram_re   = accept && (i_mode == MODE_NONZERO);

    csm_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (VECTOR_DEPTH)
    ) u_vector_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_addr),
        .i_wr_data (in_value),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_addr),
        .o_rd_data (rd_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count <= COL_COUNT_RESET;
        end else if (i_cfg_wr_en) begin
            r_col_count <= i_cfg_wr_data;
        end
    end

    // stage 1: store read in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= accept && ((i_mode == MODE_NONZERO) || (i_mode == MODE_EMPTY));
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_good  <= (i_mode == MODE_NONZERO) && col_ok;
            r_s1_bad   <= (i_mode == MODE_NONZERO) && !col_ok;
            r_s1_close <= (i_mode == MODE_EMPTY) || ((i_mode == MODE_NONZERO) && i_row_end);
            r_s1_val   <= in_value;
        end
    end

    assign product = PROD_BITS'(r_s1_val) * PROD_BITS'(rd_value);

    // stage 2: registered product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (advance) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s2_prod  <= r_s1_good ? SUM_BITS'(product) : '0;
            r_s2_bad   <= r_s1_bad;
            r_s2_close <= r_s1_close;
        end
    end

    // saturating accumulate
    assign n_sum_wide = {r_acc[SUM_BITS-1], r_acc} + {r_s2_prod[SUM_BITS-1], r_s2_prod};
    always_comb begin
        if (n_sum_wide[SUM_BITS] != n_sum_wide[SUM_BITS-1]) begin
            n_sum = n_sum_wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
        end else begin
            n_sum = n_sum_wide[SUM_BITS-1:0];
        end
    end
    assign n_err = r_err || r_s2_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_err <= 1'b0;
            r_row <= '0;
        end else if (advance && r_s2_valid) begin
            if (r_s2_close) begin
                r_acc <= '0;
                r_err <= 1'b0;
                r_row <= r_row + t_row'(1);
            end else begin
                r_acc <= n_sum;
                r_err <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s2_valid && r_s2_close;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s2_valid && r_s2_close) begin
            r_out_sum <= n_sum;
            r_out_row <= r_row;
            r_out_err <= n_err;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_row_sum      = r_out_sum;
    assign o_row_number   = r_out_row;
    assign o_column_error = r_out_err;

endmodule

// ===== sv/csm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data
`timescale 1ns / 1ps
module csm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                        i_clk,
    input  logic                                        i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                            i_wr_data,
    input  logic                                        i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                            o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/csm_checker.sv =====
// Port-level checker for csr_sparse_matvec, bound to the top level
`timescale 1ns / 1ps
`include "csr_sparse_matvec_macros.svh"
module csm_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_in_stall,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic signed [csm_pkg::SUM_BITS-1:0] o_row_sum,
    input logic [csm_pkg::ROW_BITS-1:0]        o_row_number,
    input logic                                o_column_error
);
    import csm_pkg::*;

    t_row r_exp_row;

    // rows are numbered in delivery order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_row <= '0;
        end else if (o_out_valid && !i_out_stall) begin
            r_exp_row <= r_exp_row + t_row'(1);
        end
    end

    `CSM_ASSERT_IMP(a_row_order, i_clk, i_rst_n, o_out_valid,
        o_row_number == r_exp_row, "row number out of order")
    `CSM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_row_sum) && $stable(o_row_number)
            && $stable(o_column_error), "stalled result word changed")
    `CSM_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_in_stall,
        o_out_valid && i_out_stall, "input stalled without a blocked result word")
    `CSM_ASSERT_IMP(a_reset_quiet, i_clk, i_rst_n, $past(!i_rst_n),
        !o_out_valid, "result word straight after reset")

endmodule

bind csr_sparse_matvec csm_checker u_csm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_row_sum      (o_row_sum),
    .o_row_number   (o_row_number),
    .o_column_error (o_column_error)
);

// ===== tb/sv/csr_sparse_matvec_checker.sv =====
// Row-sum checker for csr_sparse_matvec: watches both channels, predicts and compares
`timescale 1ns / 1ps
module csr_sparse_matvec_checker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    input  logic                                    i_in_stall,
    input  csm_pkg::t_mode                          i_mode,
    input  logic [csm_pkg::INDEX_BITS-1:0]          i_index,
    input  logic signed [csm_pkg::OPERAND_BITS-1:0] i_operand_value,
    input  logic                                    i_row_end,
    input  logic                                    i_cfg_wr_en,
    input  logic [csm_pkg::CFG_BITS-1:0]            i_cfg_wr_data,
    input  logic                                    i_out_valid,
    input  logic                                    i_out_stall,
    input  logic signed [csm_pkg::SUM_BITS-1:0]     i_row_sum,
    input  logic [csm_pkg::ROW_BITS-1:0]            i_row_number,
    input  logic                                    i_column_error,
    output int                                      o_fail_count,
    output int                                      o_rows_due,
    output int                                      o_rows_checked,
    output int                                      o_error_rows,
    output int                                      o_saturated_rows
);
    import csm_pkg::*;

    typedef struct packed {
        t_sum row_sum;
        t_row row_number;
        logic column_error;
    } t_row_result;

    t_value      vec_entry [VECTOR_DEPTH];
    t_sum        row_partial;
    t_row        row_idx;
    logic        row_bad;
    t_cfg        col_limit;
    t_row_result row_results_due [$];

    function automatic t_sum add_clamped(t_sum a, t_sum b);
        logic signed [SUM_BITS:0] wide;
        wide = {a[SUM_BITS-1], a} + {b[SUM_BITS-1], b};
        if (wide[SUM_BITS] != wide[SUM_BITS-1]) begin
            return wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
        end
        return wide[SUM_BITS-1:0];
    endfunction

    task automatic close_row();
        t_row_result r;
        r.row_sum      = row_partial;
        r.row_number   = row_idx;
        r.column_error = row_bad;
        row_results_due = {row_results_due, r};
        row_partial = '0;
        row_bad     = 1'b0;
        row_idx     = row_idx + t_row'(1);
    endtask

    task automatic take_word();
        logic [SUM_BITS-1:0] prod;
        t_value              held;
        case (i_mode)
            MODE_LOAD: begin
                vec_entry[i_index] = i_operand_value;
            end
            MODE_NONZERO: begin
                if ({1'b0, i_index} < col_limit) begin
                    held = vec_entry[i_index];
                    // sign-extended operands: the low 64 bits are the exact product
                    prod = {{(SUM_BITS-OPERAND_BITS){i_operand_value[OPERAND_BITS-1]}},
                            i_operand_value}
                         * {{(SUM_BITS-VALUE_BITS){held[VALUE_BITS-1]}}, held};
                    row_partial = add_clamped(row_partial, prod);
                end else begin
                    row_bad = 1'b1;
                end
                if (i_row_end) close_row();
            end
            MODE_EMPTY: begin
                close_row();
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_row_result want;
        if (!i_rst_n) begin
            row_partial = '0;
            row_idx     = '0;
            row_bad     = 1'b0;
            col_limit   = COL_COUNT_RESET;
            row_results_due.delete();
        end else begin
            if (i_cfg_wr_en) col_limit = i_cfg_wr_data;
            // compare before predicting, so a word closing a row now is never matched early
            if (i_out_valid && !i_out_stall) begin
                if (row_results_due.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected row word: sum %0d row %0d error %0b",
                                 i_row_sum, i_row_number, i_column_error);
                    o_fail_count++;
                end else begin
                    want = row_results_due.pop_front();
                    o_rows_checked++;
                    if (want.column_error) o_error_rows++;
                    if (want.row_sum == SUM_MAX || want.row_sum == SUM_MIN)
                        o_saturated_rows++;
                    if (i_row_sum !== want.row_sum || i_row_number !== want.row_number
                            || i_column_error !== want.column_error) begin
                        if (o_fail_count < 10)
                            $display({"row %0d: exp sum %0d row %0d err %0b, ",
                                      "got sum %0d row %0d err %0b"},
                                     want.row_number, want.row_sum, want.row_number,
                                     want.column_error, i_row_sum, i_row_number,
                                     i_column_error);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) take_word();
        end
        o_rows_due = row_results_due.size();
    end

endmodule

// ===== tb/sv/csr_sparse_matvec_tb.sv =====
// Testbench top for csr_sparse_matvec: clock, reset, stimulus, back-pressure and verdict
`timescale 1ns / 1ps
module csr_sparse_matvec_tb;
    import csm_pkg::*;

    localparam int    SETTLE_CYCLES  = 6;
    localparam int    HOLD_CYCLES    = 300;
    localparam int    WATCHDOG_LIMIT = 5000;
    localparam int    PART_WORDS     = 850;
    localparam t_mode MODE_UNUSED    = 2'd3;

    typedef enum {
        STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE, STALL_BLOCKS
    } t_stall_style;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_stall;
    t_mode                       i_mode;
    logic [INDEX_BITS-1:0]       i_index;
    logic signed [OPERAND_BITS-1:0] i_operand_value;
    logic                        i_row_end;
    logic                        i_cfg_wr_en;
    logic [CFG_BITS-1:0]         i_cfg_wr_data;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic signed [SUM_BITS-1:0]  o_row_sum;
    logic [ROW_BITS-1:0]         o_row_number;
    logic                        o_column_error;

    int fail_count, rows_due, rows_checked, error_rows, saturated_rows;

    bit written [VECTOR_DEPTH];
    int written_addrs [$];
    int cur_cols;
    int burst_left;
    bit steady;
    bit hold_wanted;
    bit hold_done;
    int words_sent;
    int settings_used;
    int idle_cycles;

    csr_sparse_matvec dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_index         (i_index),
        .i_operand_value (i_operand_value),
        .i_row_end       (i_row_end),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_row_sum       (o_row_sum),
        .o_row_number    (o_row_number),
        .o_column_error  (o_column_error)
    );

    csr_sparse_matvec_checker u_row_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_mode           (i_mode),
        .i_index          (i_index),
        .i_operand_value  (i_operand_value),
        .i_row_end        (i_row_end),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_row_sum        (o_row_sum),
        .i_row_number     (o_row_number),
        .i_column_error   (o_column_error),
        .o_fail_count     (fail_count),
        .o_rows_due       (rows_due),
        .o_rows_checked   (rows_checked),
        .o_error_rows     (error_rows),
        .o_saturated_rows (saturated_rows)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // nothing accepted for too long: give up
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || i_cfg_wr_en) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d rows outstanding",
                     WATCHDOG_LIMIT, rows_due);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver back-pressure, plus one long hold-off on request
    initial begin
        t_stall_style style;
        int           span;
        i_out_stall <= 1'b0;
        style = STALL_NONE;
        span  = 0;
        forever begin
            @(posedge i_clk);
            if (hold_wanted && !hold_done) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            if (span == 0) begin
                style = t_stall_style'($urandom_range(0, 4));
                span  = $urandom_range(32, 256);
            end
            span--;
            case (style)
                STALL_NONE:   i_out_stall <= 1'b0;
                STALL_LIGHT:  i_out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:  i_out_stall <= ($urandom_range(0, 3) != 0);
                STALL_TOGGLE: i_out_stall <= ~i_out_stall;
                default:      i_out_stall <= ($urandom_range(0, 15) == 0) ? ~i_out_stall
                                                                        : i_out_stall;
            endcase
        end
    end

    task automatic send_word(t_mode m, int idx, logic [31:0] v, logic e);
        int gap;
        if (burst_left == 0 && !steady) begin
            i_in_valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 16);
        end
        if (burst_left > 0) burst_left--;
        i_in_valid      <= 1'b1;
        i_mode          <= m;
        i_index         <= idx[INDEX_BITS-1:0];
        i_operand_value <= v;
        i_row_end       <= e;
        do @(posedge i_clk); while (o_in_stall);
        if (m == MODE_LOAD && !written[idx]) begin
            written[idx] = 1'b1;
            written_addrs = {written_addrs, idx};
        end
        words_sent++;
    endtask

    // hold the input until every row word is out and the pipeline has drained
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (rows_due != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cols(int value);
        wait_quiet();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value[CFG_BITS-1:0];
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_cols = (value > VECTOR_DEPTH) ? VECTOR_DEPTH : value;
        settings_used++;
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0001_0000;
            4, 5:    return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic int pick_load_addr();
        if (cur_cols > 0 && $urandom_range(0, 1)) return $urandom_range(0, cur_cols - 1);
        return $urandom_range(0, VECTOR_DEPTH - 1);
    endfunction

    // good columns only ever hit loaded entries; bad ones may be anywhere
    function automatic int pick_column();
        int c;
        if (cur_cols < VECTOR_DEPTH && $urandom_range(0, 9) == 0)
            return $urandom_range(cur_cols, VECTOR_DEPTH - 1);
        if (cur_cols > 0) begin
            c = $urandom_range(0, cur_cols - 1);
            if (written[c]) return c;
        end
        return written_addrs[$urandom_range(0, written_addrs.size() - 1)];
    endfunction

    function automatic int pick_cols_setting();
        case ($urandom_range(0, 5))
            0:       return 1;
            1:       return VECTOR_DEPTH;
            2:       return 0;
            3:       return 2047;
            4:       return $urandom_range(2, VECTOR_DEPTH - 1);
            default: return $urandom_range(VECTOR_DEPTH + 1, 2046);
        endcase
    endfunction

    task automatic issue_row();
        int len, hot, col;
        bit shut_by_empty;
        if ($urandom_range(0, 9) == 0) begin
            send_word(MODE_EMPTY, $urandom_range(0, 1023), $urandom(),
                      1'($urandom_range(0, 1)));
            return;
        end
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        shut_by_empty = ($urandom_range(0, 11) == 0);
        hot = -1;
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 19) == 0) begin
                hot = pick_load_addr();
                send_word(MODE_LOAD, hot, pick_operand(), 1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 29) == 0)
                send_word(MODE_UNUSED, $urandom_range(0, 1023), $urandom(),
                          1'($urandom_range(0, 1)));
            col = (hot >= 0 && $urandom_range(0, 1)) ? hot : pick_column();
            hot = -1;
            send_word(MODE_NONZERO, col, pick_operand(), (k == len - 1) && !shut_by_empty);
        end
        if (shut_by_empty)
            send_word(MODE_EMPTY, $urandom_range(0, 1023), $urandom(),
                      1'($urandom_range(0, 1)));
    endtask

    task automatic run_random(int count);
        int stop_at, n;
        stop_at = words_sent + count;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 3) == 0) write_cols(pick_cols_setting());
            else if ($urandom_range(0, 5) == 0) wait_quiet();
            n = $urandom_range(0, 12);
            repeat (n) send_word(MODE_LOAD, pick_load_addr(), pick_operand(),
                                 1'($urandom_range(0, 1)));
            n = $urandom_range(2, 12);
            repeat (n) issue_row();
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_mode          <= MODE_LOAD;
        i_index         <= '0;
        i_operand_value <= '0;
        i_row_end       <= 1'b0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_wr_data   <= '0;
        cur_cols   = VECTOR_DEPTH;
        burst_left = 0;
        steady     = 1'b0;
        hold_wanted = 1'b0;
        hold_done  = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, saturation both ways, row closing variants, bad columns
        write_cols(VECTOR_DEPTH);
        send_word(MODE_LOAD, 0, 32'h7FFF_FFFF, 1'b0);
        send_word(MODE_LOAD, 1023, 32'h8000_0000, 1'b0);
        send_word(MODE_LOAD, 1, 32'h0001_0000, 1'b0);
        send_word(MODE_LOAD, 2, 32'hFFFF_FFFF, 1'b1);
        send_word(MODE_NONZERO, 1023, 32'h8000_0000, 1'b0);
        send_word(MODE_NONZERO, 1023, 32'h8000_0000, 1'b0);
        send_word(MODE_NONZERO, 1023, 32'h8000_0000, 1'b1);
        send_word(MODE_NONZERO, 0, 32'h8000_0000, 1'b0);
        send_word(MODE_NONZERO, 0, 32'h8000_0000, 1'b0);
        send_word(MODE_NONZERO, 0, 32'h8000_0000, 1'b0);
        send_word(MODE_NONZERO, 1, 32'h0001_0000, 1'b1);
        send_word(MODE_EMPTY, 0, 32'h0, 1'b0);
        send_word(MODE_NONZERO, 2, 32'h7FFF_FFFF, 1'b0);
        send_word(MODE_LOAD, 3, 32'h0002_0000, 1'b0);
        send_word(MODE_NONZERO, 3, 32'hFFFF_FFFF, 1'b0);
        send_word(MODE_EMPTY, 1023, 32'hFFFF_FFFF, 1'b1);
        send_word(MODE_UNUSED, 1023, 32'hFFFF_FFFF, 1'b1);
        send_word(MODE_NONZERO, 1, 32'h7FFF_FFFF, 1'b1);
        write_cols(4);
        send_word(MODE_NONZERO, 5, 32'h1234_5678, 1'b0);
        send_word(MODE_NONZERO, 2, 32'h8000_0000, 1'b1);
        write_cols(0);
        send_word(MODE_NONZERO, 0, 32'h0000_0001, 1'b1);
        write_cols(2047);
        send_word(MODE_NONZERO, 1023, 32'h7FFF_FFFF, 1'b1);

        run_random(PART_WORDS);

        // long receiver hold-off while the sender keeps offering, then a full drain
        steady = 1'b1;
        hold_wanted = 1'b1;
        repeat (12) issue_row();
        steady = 1'b0;
        wait_quiet();

        run_random(PART_WORDS);
        wait_quiet();

        $display("covered %0d input words, %0d column-count writes, one long output hold-off",
                 words_sent, settings_used);
        $display("%0d row words checked: %0d with bad columns, %0d saturated, %0d mismatches",
                 rows_checked, error_rows, saturated_rows, fail_count);
        if (fail_count == 0 && rows_due == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
